// ----- sv/contact_detector_dwell_hysteresis_defines.svh -----
// Assertion macros for the contact detector.
`ifndef CONTACT_DETECTOR_DWELL_HYSTERESIS_DEFINES_SVH
`define CONTACT_DETECTOR_DWELL_HYSTERESIS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CDH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CDH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cdh_pkg.sv -----
// Shared types and constants for the contact detector.
package cdh_pkg;

    localparam int ACCUM_W   = 25;
    localparam int LIMIT_W   = 24;
    localparam int COORD_W   = 16;
    localparam int FTIME_W   = 20;
    localparam int DT_W      = 17;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam logic [DT_W-1:0] DT_CLAMP_US = DT_W'(100000);

    typedef enum logic [2:0] {
        REG_ACQ_HEIGHT   = 3'd0,
        REG_ACQ_PLANAR   = 3'd1,
        REG_ACQ_UP       = 3'd2,
        REG_REL_HEIGHT   = 3'd3,
        REG_REL_PLANAR   = 3'd4,
        REG_REL_UP       = 3'd5,
        REG_ENTER_LIMIT  = 3'd6,
        REG_EXIT_LIMIT   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] acquire_height;
        logic signed [COORD_W-1:0] acquire_planar_speed;
        logic signed [COORD_W-1:0] acquire_up_speed;
        logic signed [COORD_W-1:0] release_height;
        logic signed [COORD_W-1:0] release_planar_speed;
        logic signed [COORD_W-1:0] release_up_speed;
        logic        [LIMIT_W-1:0] enter_dwell_limit;
        logic        [LIMIT_W-1:0] exit_dwell_limit;
    } cfg_t;

    typedef struct packed {
        logic advance;      // request moves from input to result register
        logic frozen;       // request leaves state untouched
        logic contact;
        logic enter_zero;
        logic exit_zero;
    } status_t;

endpackage

// ----- sv/cdh_regs.sv -----
// APB configuration register file for the contact detector.
module cdh_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cdh_pkg::PADDR_W-1:0]  paddr,
    input  logic [cdh_pkg::PDATA_W-1:0]  pwdata,
    output logic [cdh_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output cdh_pkg::cfg_t                cfg
);
    import cdh_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.acquire_height       <= 16'sd80;
            cfg_reg.acquire_planar_speed <= 16'sd320;
            cfg_reg.acquire_up_speed     <= 16'sd160;
            cfg_reg.release_height       <= 16'sd128;
            cfg_reg.release_planar_speed <= 16'sd640;
            cfg_reg.release_up_speed     <= 16'sd320;
            cfg_reg.enter_dwell_limit    <= 24'd50000;
            cfg_reg.exit_dwell_limit     <= 24'd50000;
        end else if (wr_en) begin
            unique case (idx)
                REG_ACQ_HEIGHT:  cfg_reg.acquire_height       <= pwdata[COORD_W-1:0];
                REG_ACQ_PLANAR:  cfg_reg.acquire_planar_speed <= pwdata[COORD_W-1:0];
                REG_ACQ_UP:      cfg_reg.acquire_up_speed     <= pwdata[COORD_W-1:0];
                REG_REL_HEIGHT:  cfg_reg.release_height       <= pwdata[COORD_W-1:0];
                REG_REL_PLANAR:  cfg_reg.release_planar_speed <= pwdata[COORD_W-1:0];
                REG_REL_UP:      cfg_reg.release_up_speed     <= pwdata[COORD_W-1:0];
                REG_ENTER_LIMIT: cfg_reg.enter_dwell_limit    <= pwdata[LIMIT_W-1:0];
                REG_EXIT_LIMIT:  cfg_reg.exit_dwell_limit     <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ACQ_HEIGHT:  prdata = PDATA_W'(cfg_reg.acquire_height);
            REG_ACQ_PLANAR:  prdata = PDATA_W'(cfg_reg.acquire_planar_speed);
            REG_ACQ_UP:      prdata = PDATA_W'(cfg_reg.acquire_up_speed);
            REG_REL_HEIGHT:  prdata = PDATA_W'(cfg_reg.release_height);
            REG_REL_PLANAR:  prdata = PDATA_W'(cfg_reg.release_planar_speed);
            REG_REL_UP:      prdata = PDATA_W'(cfg_reg.release_up_speed);
            REG_ENTER_LIMIT: prdata = {8'd0, cfg_reg.enter_dwell_limit};
            REG_EXIT_LIMIT:  prdata = {8'd0, cfg_reg.exit_dwell_limit};
            default:         prdata = '0;
        endcase
    end

endmodule

// ----- sv/cdh_core.sv -----
// Input register, dwell/contact update and result register.
module cdh_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  cdh_pkg::cfg_t                        cfg,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [cdh_pkg::COORD_W-1:0]   s_height,
    input  logic signed [cdh_pkg::COORD_W-1:0]   s_planar_speed,
    input  logic signed [cdh_pkg::COORD_W-1:0]   s_up_speed,
    input  logic                                 s_trusted,
    input  logic        [cdh_pkg::FTIME_W-1:0]   s_frame_time_us,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_contact,
    output cdh_pkg::status_t                     status
);
    import cdh_pkg::*;

    // input stage
    logic                      in_valid_reg;
    logic signed [COORD_W-1:0] height_reg;
    logic signed [COORD_W-1:0] planar_reg;
    logic signed [COORD_W-1:0] up_reg;
    logic                      trusted_reg;
    logic        [FTIME_W-1:0] ftime_reg;

    // detector state
    logic               contact_reg, contact_next;
    logic [ACCUM_W-1:0] enter_reg, enter_next;
    logic [ACCUM_W-1:0] exit_reg, exit_next;

    // result stage
    logic out_valid_reg;
    logic out_contact_reg;

    logic               advance;
    logic               live;
    logic [DT_W-1:0]    dt;
    logic               acquire_ok;
    logic               release_hit;
    logic [ACCUM_W:0]   sum;
    logic [ACCUM_W-1:0] sat;
    logic [ACCUM_W-1:0] base;
    logic [LIMIT_W-1:0] limit;
    logic               reached;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_contact = out_contact_reg;

    always_comb begin
        live = trusted_reg && (ftime_reg != '0);
        dt   = (ftime_reg > FTIME_W'(DT_CLAMP_US)) ? DT_CLAMP_US : ftime_reg[DT_W-1:0];

        acquire_ok  = (height_reg <= cfg.acquire_height)
                   && (planar_reg <= cfg.acquire_planar_speed)
                   && (up_reg     <= cfg.acquire_up_speed);
        release_hit = (height_reg >= cfg.release_height)
                   || (planar_reg >= cfg.release_planar_speed)
                   || (up_reg     >= cfg.release_up_speed);

        // one shared saturating adder; which dwell it serves follows the flag
        base  = contact_reg ? exit_reg : enter_reg;
        limit = contact_reg ? cfg.exit_dwell_limit : cfg.enter_dwell_limit;
        sum   = {1'b0, base} + (ACCUM_W+1)'(dt);
        sat   = sum[ACCUM_W] ? '1 : sum[ACCUM_W-1:0];
        reached = sat >= ACCUM_W'(limit);

        contact_next = contact_reg;
        enter_next   = enter_reg;
        exit_next    = exit_reg;
        if (live) begin
            if (!contact_reg) begin
                if (acquire_ok) begin
                    if (reached) begin
                        contact_next = 1'b1;
                        enter_next   = '0;
                        exit_next    = '0;
                    end else begin
                        enter_next = sat;
                    end
                end else begin
                    enter_next = '0;
                end
            end else begin
                if (release_hit) begin
                    if (reached) begin
                        contact_next = 1'b0;
                        enter_next   = '0;
                        exit_next    = '0;
                    end else begin
                        exit_next = sat;
                    end
                end else begin
                    exit_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            contact_reg     <= 1'b0;
            enter_reg       <= '0;
            exit_reg        <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                contact_reg   <= contact_next;
                enter_reg     <= enter_next;
                exit_reg      <= exit_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            height_reg  <= s_height;
            planar_reg  <= s_planar_speed;
            up_reg      <= s_up_speed;
            trusted_reg <= s_trusted;
            ftime_reg   <= s_frame_time_us;
        end
        if (advance) begin
            out_contact_reg <= contact_next;
        end
    end

    assign status.advance    = advance;
    assign status.frozen     = !live;
    assign status.contact    = contact_reg;
    assign status.enter_zero = (enter_reg == '0);
    assign status.exit_zero  = (exit_reg == '0);

endmodule

// ----- sv/contact_detector_dwell_hysteresis.sv -----
// Top level of the contact detector with hysteresis and dwell timers.
//
//   channel   direction  handshake          payload
//   s_*       in         s_valid / s_ready  height, planar_speed, up_speed, trusted, frame_time_us
//   m_*       out        m_valid / m_ready  contact
//   apb       in         psel/penable       8 config registers at 4*i
//
// One request per cycle sustained while m_ready stays high; an accepted request passes the
// input register and then the result register, which drives m_valid.
// The state update is a single pass of compares and one saturating adder between
// the input register and the result register.
// A stalled result holds; a new request still enters while the input register is free.
// Reset (aresetn low, synchronous) clears contact, both dwells and the handshake state.
`include "contact_detector_dwell_hysteresis_defines.svh"

module contact_detector_dwell_hysteresis (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cdh_pkg::PADDR_W-1:0]          paddr,
    input  logic [cdh_pkg::PDATA_W-1:0]          pwdata,
    output logic [cdh_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [cdh_pkg::COORD_W-1:0]   s_height,
    input  logic signed [cdh_pkg::COORD_W-1:0]   s_planar_speed,
    input  logic signed [cdh_pkg::COORD_W-1:0]   s_up_speed,
    input  logic                                 s_trusted,
    input  logic        [cdh_pkg::FTIME_W-1:0]   s_frame_time_us,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_contact
);
    import cdh_pkg::*;

    cfg_t    cfg;
    status_t status;

    cdh_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cdh_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_height        (s_height),
        .s_planar_speed  (s_planar_speed),
        .s_up_speed      (s_up_speed),
        .s_trusted       (s_trusted),
        .s_frame_time_us (s_frame_time_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_contact       (m_contact),
        .status          (status)
    );

    // enter dwell only runs out of contact, exit dwell only in contact
    `CDH_ASSERT_SAME(a_enter_idle_in_contact, aclk, aresetn, status.contact, status.enter_zero, "enter dwell non-zero while in contact")
    `CDH_ASSERT_SAME(a_exit_idle_out_contact, aclk, aresetn, !status.contact, status.exit_zero, "exit dwell non-zero while out of contact")
    // a frozen request must not move the flag
    `CDH_ASSERT_NEXT(a_frozen_holds, aclk, aresetn, status.advance && status.frozen, status.contact == $past(status.contact), "contact changed on a frozen request")
    // the delivered result mirrors the flag just computed
    `CDH_ASSERT_NEXT(a_result_matches, aclk, aresetn, status.advance, m_valid && (m_contact == status.contact), "result differs from contact state")

endmodule
